// ===== design/lhbpm_pkg.sv =====
// Shared types, constants and helpers for the love/hate buffer pool manager.
// No dependencies; every other file of the block imports this package.
package lhbpm_pkg;

   localparam int NUM_FRAMES = 64;
   localparam int AGE_BITS   = 16;
   localparam int FRAME_BITS = $clog2(NUM_FRAMES);
   localparam int CNT_BITS   = $clog2(NUM_FRAMES + 1);
   localparam int PIN_BITS   = 8;
   localparam int TAG_BITS   = 20;
   localparam int CSR_BITS   = 7;
   localparam int STAT_BITS  = 3;

   typedef enum logic [1:0] {
      OP_PIN   = 2'd0,
      OP_UNPIN = 2'd1,
      OP_FREE  = 2'd2,
      OP_FLUSH = 2'd3
   } op_type;

   localparam logic [STAT_BITS-1:0] ST_OK         = 3'd0;
   localparam logic [STAT_BITS-1:0] ST_POOL_FULL  = 3'd1;
   localparam logic [STAT_BITS-1:0] ST_NOT_FOUND  = 3'd2;
   localparam logic [STAT_BITS-1:0] ST_NOT_PINNED = 3'd3;
   localparam logic [STAT_BITS-1:0] ST_PINNED     = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_AGE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic [PIN_BITS-1:0] pin;
      logic [AGE_BITS-1:0] love;
      logic [AGE_BITS-1:0] hate;
   } entry_type;

   typedef struct packed {
      logic [STAT_BITS-1:0]  status;
      logic [FRAME_BITS-1:0] frame;
      logic                  write_back;
      logic [TAG_BITS-1:0]   write_page_id;
      logic                  fetch_page;
      logic                  dealloc;
      logic [CNT_BITS-1:0]   unpinned_count;
   } rsp_data_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic decide;
      logic age;
      logic publish;
   } dp_cmd_type;

   typedef struct packed {
      logic walk_done;
      logic age_needed;
   } dp_stat_type;

   function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] a);
      age_inc = (a == {AGE_BITS{1'b1}}) ? a : a + AGE_BITS'(1);
   endfunction

endpackage

// ===== design/lhbpm_if.sv =====
// Request and response channel interfaces (valid/ready handshake).
// Depends on lhbpm_pkg.
interface lhbpm_req_if import lhbpm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [TAG_BITS-1:0] page_id;
   logic                empty_page;
   logic                dirty_flag;
   logic                hated_flag;

   modport source (output valid, op, page_id, empty_page, dirty_flag, hated_flag,
                   input ready);
   modport sink   (input valid, op, page_id, empty_page, dirty_flag, hated_flag,
                   output ready);
endinterface

interface lhbpm_rsp_if import lhbpm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STAT_BITS-1:0]  status;
   logic [FRAME_BITS-1:0] frame;
   logic                  write_back;
   logic [TAG_BITS-1:0]   write_page_id;
   logic                  fetch_page;
   logic                  dealloc;
   logic [CNT_BITS-1:0]   unpinned_count;

   modport source (output valid, status, frame, write_back, write_page_id, fetch_page,
                   dealloc, unpinned_count, input ready);
   modport sink   (input valid, status, frame, write_back, write_page_id, fetch_page,
                   dealloc, unpinned_count, output ready);
endinterface

// ===== design/lhbpm_ctrl.sv =====
// Sequencer for the buffer pool manager: scan, decide, age, publish.
// Depends on lhbpm_pkg.
module lhbpm_ctrl import lhbpm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_SCAN;
         S_SCAN:   if (stat.walk_done) state_in = S_DECIDE;
         S_DECIDE: state_in = stat.age_needed ? S_AGE : S_FINISH;
         S_AGE:    if (stat.walk_done) state_in = S_FINISH;
         S_FINISH: if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         S_SCAN:   cmd.scan = 1'b1;
         S_DECIDE: cmd.decide = 1'b1;
         S_AGE:    cmd.age = 1'b1;
         S_FINISH: begin
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/lhbpm_dp.sv =====
// Datapath: frame table memory, valid bits, scan reductions, ageing pass.
// Depends on lhbpm_pkg; commanded by lhbpm_ctrl.
module lhbpm_dp import lhbpm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  logic                csr_we,
   input  logic [CSR_BITS-1:0] csr_wdata,
   input  logic [1:0]          req_op,
   input  logic [TAG_BITS-1:0] req_page_id,
   input  logic                req_empty_page,
   input  logic                req_dirty_flag,
   input  logic                req_hated_flag,
   output rsp_data_type        rsp_data
);

   entry_type mem [NUM_FRAMES];
   entry_type rdata_ff;
   logic [NUM_FRAMES-1:0] valid_ff, valid_in;

   logic [CSR_BITS-1:0] csr_ff;
   op_type              op_ff;
   logic [TAG_BITS-1:0] pid_ff;
   logic                empty_ff, dirty_ff, hated_ff;
   logic [CNT_BITS-1:0] n_ff, n_in;

   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic                  rd_vld_ff;
   logic [FRAME_BITS-1:0] rd_idx_ff;
   logic                  rd_en;

   logic                  hit_ff, emp_ff, hb_ff, lb_ff;
   logic [FRAME_BITS-1:0] hit_idx_ff, emp_idx_ff, hb_idx_ff, lb_idx_ff;
   entry_type             hit_ent_ff;
   logic [AGE_BITS-1:0]   hb_age_ff, lb_age_ff;
   logic [TAG_BITS-1:0]   hb_tag_ff, lb_tag_ff;
   logic [CNT_BITS-1:0]   cnt_ff;

   rsp_data_type res_ff, res_in, out_ff;

   logic                  cur_v;
   entry_type             cur;
   logic                  we;
   logic [FRAME_BITS-1:0] waddr;
   entry_type             wdata, aged;

   // effective frame count
   always_comb begin
      if (csr_ff == '0) n_in = CNT_BITS'(1);
      else if (int'(csr_ff) > NUM_FRAMES) n_in = CNT_BITS'(NUM_FRAMES);
      else n_in = CNT_BITS'(csr_ff);
   end

   assign rd_en = (cmd.scan || cmd.age) && (idx_ff < n_ff);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.start || cmd.decide) idx_in = '0;
      else if (rd_en) idx_in = idx_ff + CNT_BITS'(1);
   end

   assign stat.walk_done  = !rd_vld_ff && (idx_ff >= n_ff);
   assign stat.age_needed = (op_ff == OP_UNPIN) && hit_ff && (hit_ent_ff.pin != '0);

   // entry just read; never-valid frames read as all-zero counters
   always_comb begin
      cur_v = valid_ff[rd_idx_ff];
      cur   = rdata_ff;
      if (!cur_v) begin
         cur.pin  = '0;
         cur.love = '0;
         cur.hate = '0;
      end
   end

   // ageing of one entry
   always_comb begin
      aged = cur;
      if (rd_idx_ff == hit_idx_ff) begin
         aged.pin = cur.pin - PIN_BITS'(1);
         if (hated_ff) aged.hate = age_inc(age_inc(cur.hate));
         else          aged.love = age_inc(age_inc(cur.love));
      end else if (hated_ff) begin
         if (cur.hate != '0) aged.hate = age_inc(cur.hate);
      end else begin
         if (cur.love != '0) aged.love = age_inc(cur.love);
      end
   end

   // decision and single-entry update
   always_comb begin
      res_in   = '0;
      we       = 1'b0;
      waddr    = hit_idx_ff;
      wdata    = hit_ent_ff;
      valid_in = valid_ff;
      res_in.unpinned_count = cnt_ff;
      if (cmd.decide) begin
         if (op_ff == OP_PIN) begin
            if (hit_ff) begin
               res_in.frame = hit_idx_ff;
               we           = 1'b1;
               if (hit_ent_ff.pin != {PIN_BITS{1'b1}})
                  wdata.pin = hit_ent_ff.pin + PIN_BITS'(1);
               if (hit_ent_ff.pin == '0)
                  res_in.unpinned_count = cnt_ff - CNT_BITS'(1);
            end else if (emp_ff || hb_ff || lb_ff) begin
               wdata.tag  = pid_ff;
               wdata.pin  = PIN_BITS'(1);
               wdata.love = '0;
               wdata.hate = '0;
               we         = 1'b1;
               res_in.fetch_page = !empty_ff;
               if (emp_ff) begin
                  waddr = emp_idx_ff;
               end else begin
                  waddr = hb_ff ? hb_idx_ff : lb_idx_ff;
                  res_in.write_back     = 1'b1;
                  res_in.write_page_id  = hb_ff ? hb_tag_ff : lb_tag_ff;
                  res_in.unpinned_count = cnt_ff - CNT_BITS'(1);
               end
               res_in.frame    = waddr;
               valid_in[waddr] = 1'b1;
            end else begin
               res_in.status = ST_POOL_FULL;
            end
         end else if (!hit_ff) begin
            res_in.status = ST_NOT_FOUND;
         end else begin
            res_in.frame = hit_idx_ff;
            case (op_ff)
               OP_UNPIN: begin
                  if (dirty_ff) begin
                     res_in.write_back    = 1'b1;
                     res_in.write_page_id = pid_ff;
                  end
                  if (hit_ent_ff.pin == '0) res_in.status = ST_NOT_PINNED;
                  else if (hit_ent_ff.pin == PIN_BITS'(1))
                     res_in.unpinned_count = cnt_ff + CNT_BITS'(1);
               end
               OP_FREE: begin
                  if (hit_ent_ff.pin != '0) res_in.status = ST_PINNED;
                  else res_in.dealloc = 1'b1;
               end
               default: begin
                  res_in.write_back    = 1'b1;
                  res_in.write_page_id = pid_ff;
               end
            endcase
         end
      end else if (cmd.age && rd_vld_ff && cur_v) begin
         we    = 1'b1;
         waddr = rd_idx_ff;
         wdata = aged;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (rd_en) rdata_ff <= mem[idx_ff[FRAME_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         csr_ff    <= CSR_BITS'(64);
         rd_vld_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         valid_ff  <= valid_in;
         rd_vld_ff <= rd_en;
         idx_ff    <= idx_in;
         if (csr_we) csr_ff <= csr_wdata;
      end
   end

   // request capture and scan reductions
   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff[FRAME_BITS-1:0];
      if (cmd.decide) res_ff <= res_in;
      if (cmd.publish) out_ff <= res_ff;
      if (cmd.start) begin
         op_ff    <= op_type'(req_op);
         pid_ff   <= req_page_id;
         empty_ff <= req_empty_page;
         dirty_ff <= req_dirty_flag;
         hated_ff <= req_hated_flag;
         n_ff     <= n_in;
         hit_ff   <= 1'b0;
         emp_ff   <= 1'b0;
         hb_ff    <= 1'b0;
         lb_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else if (cmd.scan && rd_vld_ff) begin
         if (cur_v && cur.tag == pid_ff && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= rd_idx_ff;
            hit_ent_ff <= cur;
         end
         if (!cur_v && !emp_ff) begin
            emp_ff     <= 1'b1;
            emp_idx_ff <= rd_idx_ff;
         end
         if (cur.pin == '0 && cur.love == '0 && cur.hate != '0
             && (!hb_ff || cur.hate < hb_age_ff)) begin
            hb_ff     <= 1'b1;
            hb_idx_ff <= rd_idx_ff;
            hb_age_ff <= cur.hate;
            hb_tag_ff <= cur.tag;
         end
         if (cur.pin == '0 && cur.love != '0 && (!lb_ff || cur.love > lb_age_ff)) begin
            lb_ff     <= 1'b1;
            lb_idx_ff <= rd_idx_ff;
            lb_age_ff <= cur.love;
            lb_tag_ff <= cur.tag;
         end
         if (cur_v && cur.pin == '0) cnt_ff <= cnt_ff + CNT_BITS'(1);
      end
   end

   assign rsp_data = out_ff;

endmodule

// ===== design/love_hate_buffer_pool_manager_core.sv =====
// Top level of the love/hate buffer pool manager.
// Depends on lhbpm_pkg, lhbpm_if, lhbpm_ctrl and lhbpm_dp.
//
// One request at a time: pin, unpin, free or flush of a page id, answered by
// one response. With N the effective frame count (csr register, 0 acts as 1,
// above 64 acts as 64), the frame table is a single-port-read memory walked
// one frame per cycle over the first N frames, once for lookup/victim
// search/count and once more, for an unpin that ages, for the ageing
// read-modify-write. The response sits in an output register, so the next
// request is taken while it waits. Write csr only while idle.
module love_hate_buffer_pool_manager_core import lhbpm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   lhbpm_req_if.sink           req_chan,
   lhbpm_rsp_if.source         rsp_chan,
   input  logic                csr_we,
   input  logic [CSR_BITS-1:0] csr_wdata
);

   dp_cmd_type   cmd;
   dp_stat_type  stat;
   rsp_data_type rsp_data;

   // sequencer: owns handshakes and the response valid
   lhbpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // frame table and reductions
   lhbpm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_op         (req_chan.op),
      .req_page_id    (req_chan.page_id),
      .req_empty_page (req_chan.empty_page),
      .req_dirty_flag (req_chan.dirty_flag),
      .req_hated_flag (req_chan.hated_flag),
      .rsp_data       (rsp_data)
   );

   assign rsp_chan.status         = rsp_data.status;
   assign rsp_chan.frame          = rsp_data.frame;
   assign rsp_chan.write_back     = rsp_data.write_back;
   assign rsp_chan.write_page_id  = rsp_data.write_page_id;
   assign rsp_chan.fetch_page     = rsp_data.fetch_page;
   assign rsp_chan.dealloc        = rsp_data.dealloc;
   assign rsp_chan.unpinned_count = rsp_data.unpinned_count;

endmodule
